[rtl/core/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the priority task classify sorter
// Widths, reset values, register indexes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int MAX_TASKS_DEF = 32;

    localparam int PRI_W = 16;
    localparam int LIM_W = 15;
    localparam int IDX_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [LIM_W-1:0] SYSTEM_LIMIT_RST = 15'd50;
    localparam logic [LIM_W-1:0] USER_LIMIT_RST   = 15'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_LIMIT   = 1'b1;

    // list codes
    localparam logic LIST_SYSTEM = 1'b0;
    localparam logic LIST_USER   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } pts_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic store;
        logic batch_start;
        logic read;
        logic emit;
    } pts_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_end;
        logic found;
        logic out_free;
        logic list_sel;
    } pts_status_t;

endpackage

[rtl/core/pts_ctrl.sv]
// ----------------------------------------------------------------------------
// pts_ctrl: sequencing controller
// Accept a batch, then run one memory scan per result and hand each result on.
// ----------------------------------------------------------------------------
module pts_ctrl
    import pts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        last_task,
    output logic        in_ready,
    input  pts_status_t status,
    output pts_cmd_t    cmd
);

    pts_state_t state_reg;
    pts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (last_task)
                    begin
                        cmd.batch_start = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.read = 1'b1;
                if (status.scan_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read word is compared in this cycle
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!status.found && (status.list_sel == LIST_USER))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/pts_dpath.sv]
// ----------------------------------------------------------------------------
// pts_dpath: storage, selection and output register
// Priority memory, limit registers, minimum-above-last search, result register.
// ----------------------------------------------------------------------------
module pts_dpath
    import pts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LIM_W-1:0]       cfg_wdata,
    input  logic signed [PRI_W-1:0] priority_req,
    input  pts_cmd_t               cmd,
    output pts_status_t            status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   list_select,
    output logic [IDX_W-1:0]       task_index,
    output logic                   end_of_list,
    output logic                   last_result
);

    localparam int POS_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int KEY_W = LIM_W + POS_W;

    logic [PRI_W-1:0] mem [MAX_TASKS];

    logic [LIM_W-1:0] sys_limit_reg;
    logic [LIM_W-1:0] user_limit_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] scan_addr_reg, scan_addr_next;
    logic             rd_vld_reg;
    logic [POS_W-1:0] rd_pos_reg;
    logic [PRI_W-1:0] rd_data_reg;
    logic             list_reg, list_next;
    logic             have_last_reg, have_last_next;
    logic             found_reg, found_next;
    logic [KEY_W-1:0] last_key_reg, last_key_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_list_reg, out_list_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic             out_eol_reg, out_eol_next;
    logic             out_last_reg, out_last_next;

    logic             store_ok;
    logic             below_sys;
    logic             in_user;
    logic             match;
    logic [KEY_W-1:0] cand_key;
    logic             take;
    logic             out_free;

    assign store_ok  = count_reg < CNT_W'(MAX_TASKS);
    assign out_free  = !out_valid_reg || out_ready;

    // classify the word just read against the live limits
    assign below_sys = rd_data_reg[LIM_W-1:0] < sys_limit_reg;
    assign in_user   = !below_sys && (rd_data_reg[LIM_W-1:0] <= user_limit_reg);
    assign match     = !rd_data_reg[PRI_W-1]
                       && ((list_reg == LIST_USER) ? in_user : below_sys);
    assign cand_key  = {rd_data_reg[LIM_W-1:0], rd_pos_reg};
    assign take      = rd_vld_reg && match
                       && (!have_last_reg || (cand_key > last_key_reg))
                       && (!found_reg || (cand_key < best_key_reg));

    assign status.scan_end = (CNT_W'(scan_addr_reg) == (count_reg - CNT_W'(1)));
    assign status.found    = found_reg;
    assign status.out_free = out_free;
    assign status.list_sel = list_reg;

    assign out_valid   = out_valid_reg;
    assign list_select = out_list_reg;
    assign task_index  = out_index_reg;
    assign end_of_list = out_eol_reg;
    assign last_result = out_last_reg;

    always_comb
    begin
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        list_next      = list_reg;
        have_last_next = have_last_reg;
        found_next     = found_reg;
        last_key_next  = last_key_reg;
        best_key_next  = best_key_reg;
        out_valid_next = out_valid_reg;
        out_list_next  = out_list_reg;
        out_index_next = out_index_reg;
        out_eol_next   = out_eol_reg;
        out_last_next  = out_last_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.store && store_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.read)
        begin
            scan_addr_next = scan_addr_reg + POS_W'(1);
        end

        if (take)
        begin
            found_next    = 1'b1;
            best_key_next = cand_key;
        end

        if (cmd.batch_start)
        begin
            list_next      = LIST_SYSTEM;
            have_last_next = 1'b0;
            found_next     = 1'b0;
            scan_addr_next = '0;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_list_next  = list_reg;
            found_next     = 1'b0;
            scan_addr_next = '0;
            if (found_reg)
            begin
                out_index_next = IDX_W'(best_key_reg[POS_W-1:0]);
                out_eol_next   = 1'b0;
                out_last_next  = 1'b0;
                last_key_next  = best_key_reg;
                have_last_next = 1'b1;
            end
            else
            begin
                // end marker: close this list, move on or finish the batch
                out_index_next = '0;
                out_eol_next   = 1'b1;
                out_last_next  = list_reg;
                have_last_next = 1'b0;
                list_next      = LIST_USER;
                if (list_reg == LIST_USER)
                begin
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_limit_reg  <= SYSTEM_LIMIT_RST;
            user_limit_reg <= USER_LIMIT_RST;
            count_reg      <= '0;
            scan_addr_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            list_reg       <= LIST_SYSTEM;
            have_last_reg  <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SYSTEM_LIMIT: sys_limit_reg  <= cfg_wdata;
                    REG_USER_LIMIT:   user_limit_reg <= cfg_wdata;
                    default:          ;
                endcase
            end
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= cmd.read;
            list_reg      <= list_next;
            have_last_reg <= have_last_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers and memory
    always_ff @(posedge clk)
    begin
        if (cmd.store && store_ok)
        begin
            mem[count_reg[POS_W-1:0]] <= priority_req;
        end
        rd_data_reg   <= mem[scan_addr_reg];
        rd_pos_reg    <= scan_addr_reg;
        last_key_reg  <= last_key_next;
        best_key_reg  <= best_key_next;
        out_list_reg  <= out_list_next;
        out_index_reg <= out_index_next;
        out_eol_reg   <= out_eol_next;
        out_last_reg  <= out_last_next;
    end

endmodule

[rtl/core/priority_task_classify_sort.sv]
// ----------------------------------------------------------------------------
// priority_task_classify_sort: batch priority sorter with system/user split
// Collect a batch of priorities, then emit the system list and the user list,
// each in priority order (ties in arrival order) and closed by an end marker.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  cfg     | cfg_we              | cfg_index, cfg_wdata
//  in      | in_valid / in_ready | priority_req, last_task
//  out     | out_valid/out_ready | list_select, task_index, end_of_list,
//          |                     | last_result
//
//  Cycles: while a batch is collected, one input transfer per cycle.
//  After the last item, each result costs one full scan of the stored batch
//  through the single read port of the priority memory.
//  Input is held off (in_ready low) from the last item until the final end
//  marker sits in the output register.
//  Reset: limits return to 50 and 255, the batch count clears, no item pending.
//  A stalled output holds its result and the next result waits to be emitted;
//  no result is dropped.
module priority_task_classify_sort
    import pts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [LIM_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [PRI_W-1:0] priority_req,
    input  logic                    last_task,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    list_select,
    output logic [IDX_W-1:0]        task_index,
    output logic                    end_of_list,
    output logic                    last_result
);

    pts_cmd_t    cmd;
    pts_status_t status;

    // sequencing: accept, scan, drain the read pipe, transfer a result
    pts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_task (last_task),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage and search: each scan picks the smallest key above the last one
    pts_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .priority_req (priority_req),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .list_select  (list_select),
        .task_index   (task_index),
        .end_of_list  (end_of_list),
        .last_result  (last_result)
    );

    // a result is only loaded when the output register can take it
    a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded into an occupied output register");

    // the batch-closing marker is the user list end marker
    a_last_marker : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_result) |-> (end_of_list && list_select))
        else $error("last_result on something other than the user end marker");

    // a new result appears only after the controller issued it
    a_rise_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit))
        else $error("output became valid without an emit command");

    // closing the user list returns the block to accepting input
    a_back_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !status.found && status.list_sel) |=> in_ready)
        else $error("block not ready after the final end marker");

endmodule
